// ===== rtl/core/gmds_pkg.sv =====
package gmds_pkg;

	localparam int MAX_SIDE = 16;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int POS_W    = $clog2(MAX_SIDE);
	localparam int CELL_W   = $clog2(CELLS);
	localparam int DEPTH_W  = CELL_W + 1;
	localparam int SIDE_W   = 5;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_SOLVE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [2:0] CELL_PASS  = 3'd0;
	localparam logic [2:0] CELL_WALL  = 3'd1;
	localparam logic [2:0] CELL_START = 3'd2;
	localparam logic [2:0] CELL_END   = 3'd3;
	localparam logic [2:0] CELL_VERT  = 3'd4;
	localparam logic [2:0] CELL_HORZ  = 3'd5;
	localparam logic [2:0] CELL_SEEN  = 3'd6;
	localparam logic [2:0] CELL_DEAD  = 3'd7;

	localparam logic KIND_SOLVE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] row;
		logic [3:0] col;
		logic [1:0] cell_code;
	} req_t;

	typedef struct packed {
		logic       reply_kind;
		logic       found;
		logic [2:0] cell_value;
	} rsp_t;

	typedef struct packed {
		logic [CELL_W-1:0] node;
		logic              horz;
	} stack_entry_t;

	typedef struct packed {
		logic              ren;
		logic [CELL_W-1:0] raddr;
		logic              we;
		logic [CELL_W-1:0] waddr;
		logic [2:0]        wdata;
	} grid_port_t;

	typedef struct packed {
		logic              ren;
		logic [CELL_W-1:0] raddr;
		logic              we;
		logic [CELL_W-1:0] waddr;
		stack_entry_t      wdata;
	} stack_port_t;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_DOWN,
		DIR_RIGHT,
		DIR_LEFT
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_VISIT,
		ST_PROBE,
		ST_EVAL,
		ST_DEAD,
		ST_BACK,
		ST_PATH,
		ST_SWEEP,
		ST_FIN,
		ST_REPLY
	} state_t;

endpackage

// ===== rtl/core/gmds_grid_ram.sv =====
module gmds_grid_ram (
	input  logic                clk,
	input  gmds_pkg::grid_port_t port,
	output logic [2:0]          rdata
);
	import gmds_pkg::*;

	logic [2:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (port.we) begin
			mem[port.waddr] <= port.wdata;
		end
		if (port.ren) begin
			rdata <= mem[port.raddr];
		end
	end

endmodule

// ===== rtl/core/gmds_stack_ram.sv =====
module gmds_stack_ram (
	input  logic                  clk,
	input  gmds_pkg::stack_port_t port,
	output gmds_pkg::stack_entry_t rdata
);
	import gmds_pkg::*;

	stack_entry_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (port.we) begin
			mem[port.waddr] <= port.wdata;
		end
		if (port.ren) begin
			rdata <= mem[port.raddr];
		end
	end

endmodule

// ===== rtl/core/gmds_ctrl.sv =====
module gmds_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [4:0]             side,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  gmds_pkg::req_t         req_data,
	input  logic                   out_free,
	output logic                   rsp_load,
	output gmds_pkg::rsp_t         rsp_next,
	output gmds_pkg::grid_port_t   grid_port,
	input  logic [2:0]             grid_rdata,
	output gmds_pkg::stack_port_t  stack_port,
	input  gmds_pkg::stack_entry_t stack_rdata
);
	import gmds_pkg::*;

	state_t             state_q, state_d;
	dir_t               dir_q;
	logic [CELL_W-1:0]  cursor_q, nbr_q, start_q, end_q, addr_s1;
	logic [DEPTH_W-1:0] sp_q, cnt_q;
	logic               v_s1, found_q, rd_inside_q;

	logic               accept, in_grid, ends_ok, at_end, at_start;
	logic [CELL_W-1:0]  req_idx;
	logic               probe_ok, passable, path_more, sweep_more;
	logic [CELL_W-1:0]  probe_idx;
	logic [POS_W-1:0]   cur_r, cur_c;

	assign accept  = req_valid && !req_stall;
	assign req_idx = {req_data.row[POS_W-1:0], req_data.col[POS_W-1:0]};
	assign in_grid = ({1'b0, req_data.row} < side) && ({1'b0, req_data.col} < side);
	assign ends_ok = (SIDE_W'(start_q[CELL_W-1:POS_W]) < side)
		&& (SIDE_W'(start_q[POS_W-1:0]) < side)
		&& (SIDE_W'(end_q[CELL_W-1:POS_W]) < side)
		&& (SIDE_W'(end_q[POS_W-1:0]) < side);
	assign at_end   = cursor_q == end_q;
	assign at_start = cursor_q == start_q;
	assign cur_r    = cursor_q[CELL_W-1:POS_W];
	assign cur_c    = cursor_q[POS_W-1:0];
	// border counts as wall; start is never re-entered
	assign passable = (nbr_q != start_q)
		&& ((grid_rdata == CELL_PASS) || (grid_rdata == CELL_END));
	assign path_more  = cnt_q < sp_q;
	assign sweep_more = cnt_q < DEPTH_W'(CELLS);

	always_comb begin
		probe_ok  = 1'b0;
		probe_idx = cursor_q;
		case (dir_q)
			DIR_UP: begin
				probe_ok  = cur_r != '0;
				probe_idx = cursor_q - CELL_W'(MAX_SIDE);
			end
			DIR_DOWN: begin
				probe_ok  = (SIDE_W'(cur_r) + SIDE_W'(1)) < side;
				probe_idx = cursor_q + CELL_W'(MAX_SIDE);
			end
			DIR_RIGHT: begin
				probe_ok  = (SIDE_W'(cur_c) + SIDE_W'(1)) < side;
				probe_idx = cursor_q + CELL_W'(1);
			end
			DIR_LEFT: begin
				probe_ok  = cur_c != '0;
				probe_idx = cursor_q - CELL_W'(1);
			end
			default: begin
				probe_ok  = 1'b0;
				probe_idx = cursor_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_data.req_type == REQ_SOLVE) begin
						state_d = ends_ok ? ST_VISIT : ST_REPLY;
					end else if (req_data.req_type == REQ_READ) begin
						state_d = ST_RD;
					end
				end
			end
			ST_RD:    state_d = out_free ? ST_IDLE : ST_RD;
			ST_VISIT: state_d = at_end ? ST_PATH : ST_PROBE;
			ST_PROBE: begin
				if (probe_ok) state_d = ST_EVAL;
				else if (dir_q == DIR_LEFT) state_d = ST_DEAD;
			end
			ST_EVAL: begin
				if (passable) state_d = ST_VISIT;
				else if (dir_q == DIR_LEFT) state_d = ST_DEAD;
				else state_d = ST_PROBE;
			end
			ST_DEAD:  state_d = (sp_q == '0) ? ST_SWEEP : ST_BACK;
			ST_BACK:  state_d = ST_VISIT;
			ST_PATH:  state_d = (path_more || v_s1) ? ST_PATH : ST_SWEEP;
			ST_SWEEP: state_d = (sweep_more || v_s1) ? ST_SWEEP : ST_FIN;
			ST_FIN:   state_d = ST_REPLY;
			ST_REPLY: state_d = out_free ? ST_IDLE : ST_REPLY;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = state_q != ST_IDLE;
		rsp_load   = 1'b0;
		rsp_next   = '0;
		grid_port  = '0;
		stack_port = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_grid && req_data.req_type == REQ_WRITE) begin
					grid_port.we    = 1'b1;
					grid_port.waddr = req_idx;
					grid_port.wdata = {1'b0, req_data.cell_code};
				end
				if (accept && req_data.req_type == REQ_READ) begin
					grid_port.ren   = 1'b1;
					grid_port.raddr = req_idx;
				end
			end
			ST_RD: begin
				rsp_load            = out_free;
				rsp_next.reply_kind = KIND_READ;
				rsp_next.cell_value = rd_inside_q ? grid_rdata : CELL_WALL;
			end
			ST_VISIT: begin
				if (!at_end && !at_start) begin
					grid_port.we    = 1'b1;
					grid_port.waddr = cursor_q;
					grid_port.wdata = CELL_SEEN;
				end
			end
			ST_PROBE: begin
				grid_port.ren   = probe_ok;
				grid_port.raddr = probe_idx;
			end
			ST_EVAL: begin
				stack_port.we         = passable;
				stack_port.waddr      = sp_q[CELL_W-1:0];
				stack_port.wdata.node = cursor_q;
				stack_port.wdata.horz = (dir_q == DIR_RIGHT) || (dir_q == DIR_LEFT);
			end
			ST_DEAD: begin
				if (!at_start) begin
					grid_port.we    = 1'b1;
					grid_port.waddr = cursor_q;
					grid_port.wdata = CELL_DEAD;
				end
				stack_port.ren   = sp_q != '0;
				stack_port.raddr = CELL_W'(sp_q - DEPTH_W'(1));
			end
			ST_PATH: begin
				stack_port.ren   = path_more;
				stack_port.raddr = cnt_q[CELL_W-1:0];
				grid_port.we     = v_s1;
				grid_port.waddr  = stack_rdata.node;
				grid_port.wdata  = stack_rdata.horz ? CELL_HORZ : CELL_VERT;
			end
			ST_SWEEP: begin
				grid_port.ren   = sweep_more;
				grid_port.raddr = cnt_q[CELL_W-1:0];
				grid_port.we    = v_s1 && (grid_rdata == CELL_DEAD);
				grid_port.waddr = addr_s1;
				grid_port.wdata = found_q ? CELL_PASS : CELL_SEEN;
			end
			ST_FIN: begin
				grid_port.we    = found_q;
				grid_port.waddr = start_q;
				grid_port.wdata = CELL_START;
			end
			ST_REPLY: begin
				rsp_load            = out_free;
				rsp_next.reply_kind = KIND_SOLVE;
				rsp_next.found      = found_q;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dir_q       <= DIR_UP;
			cursor_q    <= '0;
			nbr_q       <= '0;
			start_q     <= '0;
			end_q       <= '0;
			addr_s1     <= '0;
			sp_q        <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			found_q     <= 1'b0;
			rd_inside_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_inside_q <= in_grid;
						cursor_q    <= start_q;
						sp_q        <= '0;
						found_q     <= 1'b0;
						if (req_data.req_type == REQ_WRITE && in_grid) begin
							if ({1'b0, req_data.cell_code} == CELL_START) start_q <= req_idx;
							else if ({1'b0, req_data.cell_code} == CELL_END) end_q <= req_idx;
						end
					end
				end
				ST_VISIT: begin
					dir_q <= DIR_UP;
					if (at_end) begin
						found_q <= 1'b1;
						cnt_q   <= '0;
						v_s1    <= 1'b0;
					end
				end
				ST_PROBE: begin
					nbr_q <= probe_idx;
					if (!probe_ok && dir_q != DIR_LEFT) dir_q <= dir_t'(dir_q + 2'd1);
				end
				ST_EVAL: begin
					if (passable) begin
						sp_q     <= sp_q + DEPTH_W'(1);
						cursor_q <= nbr_q;
					end else if (dir_q != DIR_LEFT) begin
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				ST_DEAD: begin
					if (sp_q == '0) begin
						found_q <= 1'b0;
						cnt_q   <= '0;
						v_s1    <= 1'b0;
					end else begin
						sp_q <= sp_q - DEPTH_W'(1);
					end
				end
				ST_BACK: cursor_q <= stack_rdata.node;
				ST_PATH: begin
					if (path_more || v_s1) begin
						v_s1 <= path_more;
						if (path_more) cnt_q <= cnt_q + DEPTH_W'(1);
					end else begin
						cnt_q <= '0;
						v_s1  <= 1'b0;
					end
				end
				ST_SWEEP: begin
					v_s1    <= sweep_more;
					addr_s1 <= cnt_q[CELL_W-1:0];
					if (sweep_more) cnt_q <= cnt_q + DEPTH_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/grid_maze_dfs_solver.sv =====
// channel | signals                          | direction
// request | req_valid, req_stall, req_data   | in  (write / solve / read cell)
// reply   | rsp_valid, rsp_stall, rsp_data   | out (solve and read replies)
// config  | cfg_we, cfg_wdata                | in  (grid side)
// Cell writes go straight to the grid RAM; cell reads wait for the reply register to be free.
// Solve: probes neighbors one grid RAM read at a time, marks visited cells, writes path cells,
// then sweeps all 256 grid RAM entries.
// Reset clears control state and sets the side to 16; cell contents are undefined.
// Requests stall while any request is in progress; a held reply holds off the next
// reply until it is taken.
module grid_maze_dfs_solver (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  gmds_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output gmds_pkg::rsp_t  rsp_data,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata
);
	import gmds_pkg::*;

	logic [SIDE_W-1:0] grid_side_q, side;
	logic              out_free, rsp_load;
	rsp_t              rsp_next, rsp_q;
	logic              rsp_valid_q;
	grid_port_t        grid_port;
	stack_port_t       stack_port;
	logic [2:0]        grid_rdata;
	stack_entry_t      stack_rdata;

	always_comb begin
		if (grid_side_q == '0) side = SIDE_W'(1);
		else if (grid_side_q > SIDE_W'(MAX_SIDE)) side = SIDE_W'(MAX_SIDE);
		else side = grid_side_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_W'(MAX_SIDE);
		end else if (cfg_we) begin
			grid_side_q <= cfg_wdata;
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= rsp_next;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	gmds_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.side        (side),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_data    (req_data),
		.out_free    (out_free),
		.rsp_load    (rsp_load),
		.rsp_next    (rsp_next),
		.grid_port   (grid_port),
		.grid_rdata  (grid_rdata),
		.stack_port  (stack_port),
		.stack_rdata (stack_rdata)
	);

	gmds_grid_ram u_grid (
		.clk   (clk),
		.port  (grid_port),
		.rdata (grid_rdata)
	);

	gmds_stack_ram u_stack (
		.clk   (clk),
		.port  (stack_port),
		.rdata (stack_rdata)
	);

endmodule
